/* hdl/call_site_histogram_table_defines.svh */
// assertion macros for the call site histogram table
`ifndef CALL_SITE_HISTOGRAM_TABLE_DEFINES_SVH
`define CALL_SITE_HISTOGRAM_TABLE_DEFINES_SVH

// condition must be followed by consequence on the next cycle
`define CSHT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

// condition implies consequence in the same cycle
`define CSHT_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/csht_pkg.sv */
`default_nettype none
package csht_pkg;
	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_REPORT = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_REPORTED = 3'd3;
	localparam logic [2:0] ST_NONE     = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_UPD,
		S_REP_SCAN,
		S_REP_WAIT,
		S_REP_EVAL,
		S_EMIT_RD,
		S_EMIT_WAIT,
		S_EMIT,
		S_READ_WAIT,
		S_DONE
	} state_t;

	// one stored entry
	typedef struct packed {
		logic [31:0] site;
		logic [2:0]  cat;
		logic [19:0] line;
		logic [11:0] col;
		logic [31:0] hits;
		logic [31:0] mn;
		logic [31:0] mx;
	} entry_t;
endpackage
`default_nettype wire

/* hdl/call_site_histogram_table.sv */
`default_nettype none
// call site histogram table
// requests enter on start while busy is low; all fields are sampled at that edge.
// each result appears for one cycle with valid high; last marks the final one of a request.
// record: scans stored entries one at a time (read, then compare) through a single
//   memory read port; a miss appends a new entry, or reports full if none is free;
//   a hit ends the scan early with a read-modify-write of the matching entry.
// report: walks all stored entries from newest to oldest and keeps those of the category,
//   with an extra compare step once the kept slots are full, then emits the kept slots
//   one at a time; with no kept slot a single result with status none is shown.
// read: the addressed entry is read from memory and then shown; ignored requests show status none.
// busy stays high from acceptance and drops in the cycle the last result is shown.
// reset clears the fill count and the control state; memory contents are left alone,
// only entries below the fill count are ever read, so no clearing pass is needed.
// the receiver cannot stall: each result is taken in the cycle it is shown.
module call_site_histogram_table #(
	parameter int TABLE_ENTRIES = 256,
	parameter int TOP_COUNT = 10,
	parameter int CATEGORY_COUNT = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [2:0]  category,
	input  wire logic [31:0] site_id,
	input  wire logic [19:0] line_number,
	input  wire logic [11:0] column,
	input  wire logic [31:0] request_size,
	input  wire logic [7:0]  slot_index,
	output logic             valid,
	output logic [2:0]       status,
	output logic [2:0]       entry_category,
	output logic [31:0]      entry_site,
	output logic [19:0]      entry_line,
	output logic [11:0]      entry_column,
	output logic [31:0]      hit_count,
	output logic [31:0]      smallest_size,
	output logic [31:0]      largest_size,
	output logic             last
);
`include "call_site_histogram_table_defines.svh"

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int KW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
	localparam int NW = $clog2(TOP_COUNT + 1);

	csht_pkg::entry_t mem [TABLE_ENTRIES];
	csht_pkg::entry_t rd_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic [AW-1:0] wr_addr;
	logic wr_en;
	csht_pkg::entry_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	csht_pkg::state_t state_q, state_d;
	logic [AW:0] used_q, used_d;
	logic [AW:0] ptr_q, ptr_d;
	logic [2:0] cat_q;
	logic [31:0] site_q, size_q;
	logic [19:0] line_q;
	logic [11:0] col_q;
	logic [AW-1:0] kept_q [TOP_COUNT];
	logic [31:0] khits_q [TOP_COUNT];
	logic [NW-1:0] nkept_q, nkept_d;
	logic [KW-1:0] low_q;
	logic [KW-1:0] ek_q, ek_d;
	logic [AW-1:0] hit_addr_q;
	logic load_in, kept_we, scan_found;
	logic [KW-1:0] kept_wi;

	// output register
	logic out_we;
	logic [2:0] o_status;
	csht_pkg::entry_t o_ent;
	logic o_last;

	// first minimum of the kept counts
	logic [KW-1:0] low_d;
	always_comb begin
		low_d = '0;
		for (int k = 1; k < TOP_COUNT; k++)
			if (khits_q[low_d] > khits_q[k])
				low_d = KW'(k);
	end

	assign scan_found = (rd_q.site == site_q) && (rd_q.cat == cat_q)
		&& (rd_q.line == line_q) && (rd_q.col == col_q);

	always_comb begin
		state_d = state_q;
		used_d = used_q;
		ptr_d = ptr_q;
		nkept_d = nkept_q;
		ek_d = ek_q;
		rd_en = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = hit_addr_q;
		wr_data = rd_q;
		load_in = 1'b0;
		kept_we = 1'b0;
		kept_wi = '0;
		out_we = 1'b0;
		o_status = csht_pkg::ST_NONE;
		o_ent = '0;
		o_last = 1'b1;
		case (state_q)
			csht_pkg::S_IDLE: begin
				if (start) begin
					load_in = 1'b1;
					ptr_d = '0;
					nkept_d = '0;
					ek_d = '0;
					if (opcode == csht_pkg::OP_RECORD && 32'(category) < CATEGORY_COUNT)
						state_d = csht_pkg::S_SCAN;
					else if (opcode == csht_pkg::OP_REPORT
						&& 32'(category) < CATEGORY_COUNT) begin
						ptr_d = used_q;
						state_d = csht_pkg::S_REP_SCAN;
					end else if (opcode == csht_pkg::OP_READ
						&& 32'(slot_index) < 32'(used_q)
						&& 32'(slot_index) < TABLE_ENTRIES) begin
						rd_en = 1'b1;
						rd_addr = AW'(slot_index);
						// a read emits exactly one entry
						nkept_d = NW'(1);
						state_d = csht_pkg::S_READ_WAIT;
					end else
						state_d = csht_pkg::S_DONE;
				end
			end
			csht_pkg::S_SCAN: begin
				if (ptr_q < used_q) begin
					rd_en = 1'b1;
					state_d = csht_pkg::S_SCAN_WAIT;
				end else if (used_q >= (AW+1)'(TABLE_ENTRIES)) begin
					out_we = 1'b1;
					o_status = csht_pkg::ST_FULL;
					o_ent.site = site_q;
					o_ent.cat = cat_q;
					o_ent.line = line_q;
					o_ent.col = col_q;
					state_d = csht_pkg::S_IDLE;
				end else begin
					wr_en = 1'b1;
					wr_addr = used_q[AW-1:0];
					wr_data.site = site_q;
					wr_data.cat = cat_q;
					wr_data.line = line_q;
					wr_data.col = col_q;
					wr_data.hits = 32'd1;
					wr_data.mn = size_q;
					wr_data.mx = size_q;
					used_d = used_q + 1'b1;
					out_we = 1'b1;
					o_status = csht_pkg::ST_NEW;
					o_ent = wr_data;
					state_d = csht_pkg::S_IDLE;
				end
			end
			csht_pkg::S_SCAN_WAIT: begin
				if (scan_found)
					state_d = csht_pkg::S_UPD;
				else begin
					ptr_d = ptr_q + 1'b1;
					state_d = csht_pkg::S_SCAN;
				end
			end
			csht_pkg::S_UPD: begin
				// rd_q still holds the matching entry
				wr_en = 1'b1;
				wr_addr = ptr_q[AW-1:0];
				if (rd_q.hits != '1)
					wr_data.hits = rd_q.hits + 1'b1;
				if (rd_q.mn > size_q)
					wr_data.mn = size_q;
				if (rd_q.mx < size_q)
					wr_data.mx = size_q;
				out_we = 1'b1;
				o_status = csht_pkg::ST_UPDATED;
				o_ent = wr_data;
				state_d = csht_pkg::S_IDLE;
			end
			csht_pkg::S_REP_SCAN: begin
				if (ptr_q != '0) begin
					rd_en = 1'b1;
					rd_addr = AW'(ptr_q - 1'b1);
					ptr_d = ptr_q - 1'b1;
					state_d = csht_pkg::S_REP_WAIT;
				end else if (nkept_q == '0)
					state_d = csht_pkg::S_DONE;
				else
					state_d = csht_pkg::S_EMIT_RD;
			end
			csht_pkg::S_REP_WAIT: begin
				state_d = csht_pkg::S_REP_SCAN;
				if (rd_q.cat == cat_q) begin
					if (32'(nkept_q) < TOP_COUNT) begin
						kept_we = 1'b1;
						kept_wi = KW'(nkept_q);
						nkept_d = nkept_q + 1'b1;
					end else
						state_d = csht_pkg::S_REP_EVAL;
				end
			end
			csht_pkg::S_REP_EVAL: begin
				if (khits_q[low_q] < rd_q.hits) begin
					kept_we = 1'b1;
					kept_wi = low_q;
				end
				state_d = csht_pkg::S_REP_SCAN;
			end
			csht_pkg::S_EMIT_RD: begin
				rd_en = 1'b1;
				rd_addr = kept_q[ek_q];
				state_d = csht_pkg::S_EMIT_WAIT;
			end
			csht_pkg::S_EMIT_WAIT: state_d = csht_pkg::S_EMIT;
			csht_pkg::S_EMIT: begin
				out_we = 1'b1;
				o_status = csht_pkg::ST_REPORTED;
				o_ent = rd_q;
				o_last = (32'(ek_q) + 1 == 32'(nkept_q));
				if (o_last)
					state_d = csht_pkg::S_IDLE;
				else begin
					ek_d = ek_q + 1'b1;
					state_d = csht_pkg::S_EMIT_RD;
				end
			end
			csht_pkg::S_READ_WAIT: state_d = csht_pkg::S_EMIT;
			csht_pkg::S_DONE: begin
				out_we = 1'b1;
				state_d = csht_pkg::S_IDLE;
			end
			default: state_d = csht_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csht_pkg::S_IDLE;
			used_q <= '0;
			valid <= 1'b0;
			ptr_q <= '0;
			nkept_q <= '0;
			ek_q <= '0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			valid <= out_we;
			ptr_q <= ptr_d;
			nkept_q <= nkept_d;
			ek_q <= ek_d;
		end
	end

	always_ff @(posedge clk) begin
		low_q <= low_d;
		if (state_q == csht_pkg::S_SCAN_WAIT)
			hit_addr_q <= ptr_q[AW-1:0];
		if (load_in) begin
			cat_q <= category;
			site_q <= site_id;
			line_q <= line_number;
			col_q <= column;
			size_q <= request_size;
		end
		if (kept_we) begin
			kept_q[kept_wi] <= ptr_q[AW-1:0];
			khits_q[kept_wi] <= rd_q.hits;
		end
		if (out_we) begin
			status <= o_status;
			entry_category <= o_ent.cat;
			entry_site <= o_ent.site;
			entry_line <= o_ent.line;
			entry_column <= o_ent.col;
			hit_count <= o_ent.hits;
			smallest_size <= o_ent.mn;
			largest_size <= o_ent.mx;
			last <= o_last;
		end
	end

	assign busy = (state_q != csht_pkg::S_IDLE);

	`CSHT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`CSHT_ASSERT_NOW(a_used_bound, clk, arst_n, 1'b1, used_q <= (AW+1)'(TABLE_ENTRIES))
	`CSHT_ASSERT_NOW(a_kept_bound, clk, arst_n, 1'b1, 32'(nkept_q) <= TOP_COUNT)
	`CSHT_ASSERT_NOW(a_last_idle, clk, arst_n, valid && last, !busy)
endmodule
`default_nettype wire

/* sim/csht_checker.sv */
`timescale 1ns / 1ps
module csht_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [2:0]  category,
	input  wire logic [31:0] site_id,
	input  wire logic [19:0] line_number,
	input  wire logic [11:0] column,
	input  wire logic [31:0] request_size,
	input  wire logic [7:0]  slot_index,
	input  wire logic        valid,
	input  wire logic [2:0]  status,
	input  wire logic [2:0]  entry_category,
	input  wire logic [31:0] entry_site,
	input  wire logic [19:0] entry_line,
	input  wire logic [11:0] entry_column,
	input  wire logic [31:0] hit_count,
	input  wire logic [31:0] smallest_size,
	input  wire logic [31:0] largest_size,
	input  wire logic        last,
	output int               fail_count,
	output int               outstanding
);
	localparam int ENTRIES = 256;
	localparam int TOP_SLOTS = 10;
	localparam int CATEGORIES = 5;

	typedef struct packed {
		logic [2:0]       st;
		csht_pkg::entry_t e;
		logic             lst;
	} site_result_t;

	csht_pkg::entry_t site_table[ENTRIES];
	int               fill;
	site_result_t     expected_results[$];
	int               errors;

	task automatic push_result(input logic [2:0] st, input csht_pkg::entry_t e,
		input logic lst);
		site_result_t r;
		r.st = st;
		r.e = e;
		r.lst = lst;
		expected_results.push_back(r);
	endtask

	task automatic predict_histogram(input logic [1:0] op, input logic [2:0] cat,
		input logic [31:0] site, input logic [19:0] line, input logic [11:0] col,
		input logic [31:0] size, input logic [7:0] idx);
		csht_pkg::entry_t blank;
		csht_pkg::entry_t e;
		int     kept[TOP_SLOTS];
		int     nkept;
		int     low;
		bit     found;
		blank = '0;
		e = '0;
		nkept = 0;
		found = 0;
		if (op == csht_pkg::OP_RECORD) begin
			if (cat >= CATEGORIES) begin
				push_result(csht_pkg::ST_NONE, blank, 1'b1);
			end else begin
				for (int i = 0; i < fill && !found; i++) begin
					if (site_table[i].site == site && site_table[i].cat == cat &&
					    site_table[i].line == line && site_table[i].col == col) begin
						found = 1;
						if (site_table[i].hits != '1)
							site_table[i].hits++;
						if (site_table[i].mn > size)
							site_table[i].mn = size;
						if (site_table[i].mx < size)
							site_table[i].mx = size;
						push_result(csht_pkg::ST_UPDATED, site_table[i], 1'b1);
					end
				end
				if (!found) begin
					e.site = site;
					e.cat = cat;
					e.line = line;
					e.col = col;
					if (fill >= ENTRIES) begin
						push_result(csht_pkg::ST_FULL, e, 1'b1);
					end else begin
						e.hits = 1;
						e.mn = size;
						e.mx = size;
						site_table[fill] = e;
						fill++;
						push_result(csht_pkg::ST_NEW, e, 1'b1);
					end
				end
			end
		end else if (op == csht_pkg::OP_REPORT) begin
			if (cat < CATEGORIES) begin
				// newest to oldest, replace first lowest count on a strictly larger one
				for (int s = fill - 1; s >= 0; s--) begin
					if (site_table[s].cat == cat) begin
						if (nkept < TOP_SLOTS) begin
							kept[nkept] = s;
							nkept++;
						end else begin
							low = 0;
							for (int k = 1; k < TOP_SLOTS; k++)
								if (site_table[kept[low]].hits > site_table[kept[k]].hits)
									low = k;
							if (site_table[kept[low]].hits < site_table[s].hits)
								kept[low] = s;
						end
					end
				end
			end
			if (nkept == 0)
				push_result(csht_pkg::ST_NONE, blank, 1'b1);
			for (int k = 0; k < nkept; k++)
				push_result(csht_pkg::ST_REPORTED, site_table[kept[k]], k == nkept - 1);
		end else if (op == csht_pkg::OP_READ && idx < fill) begin
			push_result(csht_pkg::ST_REPORTED, site_table[idx], 1'b1);
		end else begin
			push_result(csht_pkg::ST_NONE, blank, 1'b1);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		site_result_t r;
		if (!arst_n) begin
			fill = 0;
			expected_results.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (start && !busy)
				predict_histogram(opcode, category, site_id, line_number, column,
					request_size, slot_index);
			if (valid) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result with status %0d", status);
					errors++;
				end else begin
					r = expected_results.pop_front();
					check_field("status", r.st, status);
					check_field("entry_category", r.e.cat, entry_category);
					check_field("entry_site", r.e.site, entry_site);
					check_field("entry_line", r.e.line, entry_line);
					check_field("entry_column", r.e.col, entry_column);
					check_field("hit_count", r.e.hits, hit_count);
					check_field("smallest_size", r.e.mn, smallest_size);
					check_field("largest_size", r.e.mx, largest_size);
					check_field("last", r.lst, last);
				end
			end
			fail_count <= errors;
			outstanding <= expected_results.size();
		end
	end
endmodule

/* sim/call_site_histogram_table_tb.sv */
`timescale 1ns / 1ps
module call_site_histogram_table_tb;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [2:0]  category;
	logic [31:0] site_id;
	logic [19:0] line_number;
	logic [11:0] column;
	logic [31:0] request_size;
	logic [7:0]  slot_index;
	logic        valid;
	logic [2:0]  status;
	logic [2:0]  entry_category;
	logic [31:0] entry_site;
	logic [19:0] entry_line;
	logic [11:0] entry_column;
	logic [31:0] hit_count;
	logic [31:0] smallest_size;
	logic [31:0] largest_size;
	logic        last;
	int          fail_count;
	int          outstanding;

	logic [2:0]  pool_cat[16];
	logic [31:0] pool_site[16];
	logic [19:0] pool_line[16];
	logic [11:0] pool_col[16];
	int          burst_left;

	call_site_histogram_table dut (.*);

	csht_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// drive one request and hold it until accepted
	task automatic send(input logic [1:0] op, input logic [2:0] cat, input logic [31:0] site,
		input logic [19:0] line, input logic [11:0] col, input logic [31:0] size,
		input logic [7:0] idx);
		start <= 1'b1;
		opcode <= op;
		category <= cat;
		site_id <= site;
		line_number <= line;
		column <= col;
		request_size <= size;
		slot_index <= idx;
		do @(posedge clk); while (busy);
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
	endtask

	task automatic record_fresh();
		send(csht_pkg::OP_RECORD, 3'($urandom_range(0, 4)), $urandom, 20'($urandom),
			12'($urandom), $urandom, 8'd0);
	endtask

	task automatic random_request();
		int r;
		int p;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, 15);
		if (r < 40)
			send(csht_pkg::OP_RECORD, pool_cat[p], pool_site[p], pool_line[p], pool_col[p],
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096),
				8'($urandom));
		else if (r < 62)
			record_fresh();
		else if (r < 78)
			send(csht_pkg::OP_REPORT, 3'($urandom_range(0, 5)), $urandom, 20'($urandom),
				12'($urandom), $urandom, 8'($urandom));
		else if (r < 94)
			send(csht_pkg::OP_READ, 3'($urandom), $urandom, 20'($urandom), 12'($urandom),
				$urandom, $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 40)));
		else if (r < 97)
			send(csht_pkg::OP_NONE, 3'($urandom), $urandom, 20'($urandom), 12'($urandom),
				$urandom, 8'($urandom));
		else
			send(csht_pkg::OP_RECORD, 3'($urandom_range(5, 7)), $urandom, 20'($urandom),
				12'($urandom), $urandom, 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = '0;
		category = '0;
		site_id = '0;
		line_number = '0;
		column = '0;
		request_size = '0;
		slot_index = '0;
		burst_left = 1;
		// most pool keys share category 0 so the top-ten replacement gets exercised
		for (int i = 0; i < 16; i++) begin
			pool_cat[i] = (i < 12) ? 3'd0 : 3'($urandom_range(1, 4));
			pool_site[i] = $urandom;
			pool_line[i] = 20'($urandom);
			pool_col[i] = 12'($urandom);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(csht_pkg::OP_REPORT, 3'd0, 0, 0, 0, 0, 0);
		send(csht_pkg::OP_READ, 3'd0, 0, 0, 0, 0, 8'd0);
		send(csht_pkg::OP_NONE, 3'd7, '1, '1, '1, '1, '1);
		send(csht_pkg::OP_RECORD, 3'd5, 1, 2, 3, 4, 0);
		send(csht_pkg::OP_RECORD, 3'd7, '1, '1, '1, '1, '1);
		send(csht_pkg::OP_REPORT, 3'd6, 0, 0, 0, 0, 0);
		send(csht_pkg::OP_RECORD, 3'd1, 32'h1234, 20'd55, 12'd7, 32'd0, 0);
		send(csht_pkg::OP_RECORD, 3'd1, 32'h1234, 20'd55, 12'd7, 32'hffff_ffff, 0);
		send(csht_pkg::OP_RECORD, 3'd1, 32'h1234, 20'd55, 12'd7, 32'd100, 0);
		send(csht_pkg::OP_RECORD, 3'd4, '1, '1, '1, 32'd9, '1);
		send(csht_pkg::OP_RECORD, 3'd0, 0, 0, 0, 0, 0);
		send(csht_pkg::OP_RECORD, 3'd2, 32'h1234, 20'd55, 12'd7, 32'd8, 0);
		send(csht_pkg::OP_RECORD, 3'd3, 32'h1234, 20'd55, 12'd0, 32'd8, 0);
		send(csht_pkg::OP_READ, 3'd0, 0, 0, 0, 0, 8'd0);
		send(csht_pkg::OP_READ, 3'd0, 0, 0, 0, 0, 8'd2);
		send(csht_pkg::OP_READ, 3'd0, 0, 0, 0, 0, 8'd5);
		send(csht_pkg::OP_READ, 3'd0, 0, 0, 0, 0, 8'd255);
		send(csht_pkg::OP_REPORT, 3'd1, 0, 0, 0, 0, 0);
		send(csht_pkg::OP_REPORT, 3'd4, 0, 0, 0, 0, 0);
		send(csht_pkg::OP_REPORT, 3'd2, 0, 0, 0, 0, 0);

		repeat (60) random_request();

		// drain completely once before filling the table
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (3) @(posedge clk);

		// enough fresh keys to fill the table and hit the dropped case
		repeat (230) record_fresh();
		send(csht_pkg::OP_READ, 3'd0, 0, 0, 0, 0, 8'd255);
		send(csht_pkg::OP_REPORT, 3'd0, 0, 0, 0, 0, 0);
		repeat (50) random_request();

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
